@@ design/chra_pkg.sv @@
// Types and constants shared by the compass heading pipeline.
package chra_pkg;

   localparam int XY_WIDTH    = 36;
   localparam int Z_WIDTH     = 28;
   localparam int AXIS_WIDTH  = 16;
   localparam int ROUND_SHIFT = 11;
   localparam int TABLE_DEPTH = 24;

   localparam logic [1:0] PLANE_XY = 2'd0;
   localparam logic [1:0] PLANE_YZ = 2'd1;
   localparam logic [1:0] PLANE_ZX = 2'd2;

   localparam logic [AXIS_WIDTH-1:0]   MARKER_RESET = 16'hF000;
   localparam logic signed [Z_WIDTH-1:0] PI_FX      = 28'sd52707179;
   localparam logic signed [Z_WIDTH-1:0] TWO_PI_FX  = 28'sd105414357;
   localparam logic signed [Z_WIDTH-1:0] ROUND_HALF = 28'sd1024;
   localparam logic [15:0]             HEADING_MAX  = 16'd51471;

   localparam logic signed [Z_WIDTH-1:0] ATAN_TABLE [TABLE_DEPTH] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
      28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
      28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
      28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
      28'sd256,      28'sd128,     28'sd64,      28'sd32,
      28'sd16,       28'sd8,       28'sd4,       28'sd2
   };

   typedef struct packed {
      logic [7:0] x_high;
      logic [7:0] x_low;
      logic [7:0] z_high;
      logic [7:0] z_low;
      logic [7:0] y_high;
      logic [7:0] y_low;
      logic [1:0] func;
      logic       sample_ready;
   } req_item_type;

   typedef struct packed {
      logic [15:0] heading;
      logic        failed;
   } rsp_item_type;

   typedef struct packed {
      logic signed [XY_WIDTH-1:0] x;
      logic signed [XY_WIDTH-1:0] y;
      logic signed [Z_WIDTH-1:0]  z;
      logic                       failed;
      logic                       zero;
   } cordic_data_type;

endpackage

@@ design/chra_stream_if.sv @@
// Valid/ready item channel with a typed payload.
interface chra_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ design/compass_heading_from_raw_axes.sv @@
// Top level: magnetometer sample to compass heading through a pipelined CORDIC.
//
// Takes one item per cycle while rsp is not stalled and gives one result per
// item; each item passes through every stage of the pipeline (input stage,
// one cell per CORDIC rotation, output stage). Every stage holds its own
// item, so a stalled result holds only the stages behind it that are full.
// The heading is atan2 of the selected plane in radians, unsigned Q3.13,
// limited to 51471; a sample that is not ready or holds the overflow marker
// on any axis gives heading 0 with failed set. The marker register resets to
// 0xF000; the user must write it through csr_write_enable only while no item
// is in flight, and the block itself does not enforce this.
module compass_heading_from_raw_axes
   import chra_pkg::*;
#(
   parameter int unsigned CORDIC_STAGES = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [AXIS_WIDTH-1:0] csr_write_data,
   chra_stream_if.sink           req,
   chra_stream_if.source         rsp
);

   logic [AXIS_WIDTH-1:0] marker_ff;
   logic                  stage_valid [CORDIC_STAGES+1];
   logic                  stage_ready [CORDIC_STAGES+1];
   cordic_data_type       stage_data  [CORDIC_STAGES+1];
   req_item_type          req_item;
   rsp_item_type          rsp_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= MARKER_RESET;
      end else if (csr_write_enable) begin
         marker_ff <= csr_write_data;
      end
   end

   assign req_item = req.payload;

   chra_front u_front (
      .clock     (clock),
      .reset     (reset),
      .marker    (marker_ff),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_item   (req_item),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      chra_cell #(.STAGE_INDEX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   chra_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[CORDIC_STAGES]),
      .in_ready  (stage_ready[CORDIC_STAGES]),
      .in_data   (stage_data[CORDIC_STAGES]),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_item  (rsp_item)
   );

   assign rsp.payload = rsp_item;

endmodule

@@ design/chra_front.sv @@
// Input stage: assemble axes, check the marker, pick the plane and pre-rotate.
module chra_front
   import chra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [AXIS_WIDTH-1:0] marker,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  req_item_type          in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cordic_data_type       out_data
);

   logic                   valid_ff, valid_in;
   cordic_data_type        data_ff, data_in;
   logic [AXIS_WIDTH-1:0]  x_raw, y_raw, z_raw;
   logic [AXIS_WIDTH-1:0]  num, den;
   logic signed [XY_WIDTH-1:0] num_ext, den_ext;

   assign x_raw = {in_item.x_high, in_item.x_low};
   assign y_raw = {in_item.y_high, in_item.y_low};
   assign z_raw = {in_item.z_high, in_item.z_low};

   always_comb begin
      unique case (in_item.func)
         PLANE_YZ: begin
            num = z_raw;
            den = y_raw;
         end
         PLANE_ZX: begin
            num = x_raw;
            den = z_raw;
         end
         default: begin
            num = y_raw;
            den = x_raw;
         end
      endcase
   end

   assign num_ext = {{(XY_WIDTH-AXIS_WIDTH-16){num[AXIS_WIDTH-1]}}, num, 16'h0000};
   assign den_ext = {{(XY_WIDTH-AXIS_WIDTH-16){den[AXIS_WIDTH-1]}}, den, 16'h0000};

   always_comb begin
      data_in.failed = !in_item.sample_ready || (x_raw == marker) || (y_raw == marker)
                       || (z_raw == marker);
      data_in.zero   = (num == '0) && (den == '0);
      if (den[AXIS_WIDTH-1]) begin
         data_in.x = -den_ext;
         data_in.y = -num_ext;
         data_in.z = PI_FX;
      end else begin
         data_in.x = den_ext;
         data_in.y = num_ext;
         data_in.z = '0;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ design/chra_cell.sv @@
// One CORDIC vectoring rotation with its own item register.
module chra_cell
   import chra_pkg::*;
#(
   parameter int unsigned STAGE_INDEX = 0
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  cordic_data_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output cordic_data_type out_data
);

   logic                       valid_ff, valid_in;
   cordic_data_type            data_ff, data_in;
   logic signed [XY_WIDTH-1:0] x_shift, y_shift;

   assign x_shift = in_data.x >>> STAGE_INDEX;
   assign y_shift = in_data.y >>> STAGE_INDEX;

   always_comb begin
      data_in = in_data;
      if (!in_data.y[XY_WIDTH-1]) begin
         data_in.x = in_data.x + y_shift;
         data_in.y = in_data.y - x_shift;
         data_in.z = in_data.z + ATAN_TABLE[STAGE_INDEX];
      end else begin
         data_in.x = in_data.x - y_shift;
         data_in.y = in_data.y + x_shift;
         data_in.z = in_data.z - ATAN_TABLE[STAGE_INDEX];
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ design/chra_back.sv @@
// Output stage: wrap the angle, round to Q3.13, limit and hold the result.
module chra_back
   import chra_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  cordic_data_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_item_type    out_item
);

   logic                      valid_ff, valid_in;
   rsp_item_type              item_ff, item_in;
   logic signed [Z_WIDTH-1:0] z_wrap, z_round;
   logic [15:0]               heading_raw;

   always_comb begin
      if (in_data.z[Z_WIDTH-1]) begin
         z_wrap = in_data.z + TWO_PI_FX;
      end else if (in_data.z >= TWO_PI_FX) begin
         z_wrap = in_data.z - TWO_PI_FX;
      end else begin
         z_wrap = in_data.z;
      end
   end

   assign z_round     = z_wrap + ROUND_HALF;
   assign heading_raw = z_round[Z_WIDTH-2:ROUND_SHIFT];

   always_comb begin
      item_in.failed = in_data.failed;
      if (in_data.failed || in_data.zero) begin
         item_in.heading = '0;
      end else if (heading_raw > HEADING_MAX) begin
         item_in.heading = HEADING_MAX;
      end else begin
         item_in.heading = heading_raw;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
